### sv/vdk_pkg.sv
// shared types and constants of the velocity differentiator kalman bank
`timescale 1ns / 1ps
package vdk_pkg;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned CH_W         = 4;
  localparam int unsigned VEL_W        = 32;
  localparam int unsigned IVL_W        = 24;
  localparam int unsigned ACC_W        = 32;
  localparam int unsigned DIFF_W       = 33;
  localparam int unsigned DIV_W        = 56;
  localparam int unsigned DIV_CNT_W    = 5;
  localparam int unsigned QUOT_W       = 32;
  localparam int unsigned CFG_IDX_W    = 8;

  localparam logic [19:0]        MICROS     = 20'd1000000;
  localparam logic [IVL_W-1:0]   MIN_IVL    = 24'd1;
  localparam logic [31:0]        COV_RESET  = 32'd65536;
  localparam logic [31:0]        QN_RESET   = 32'd32768;
  localparam logic [31:0]        RN_RESET   = 32'd262144;
  localparam logic [DIV_CNT_W-1:0] ITER_RAW  = 5'd31;
  localparam logic [DIV_CNT_W-1:0] ITER_GAIN = 5'd16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN     = 8'd3;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_HOLD,
    KIND_CALC
  } kind_e;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    kind_e                    kind;
    logic signed [DIFF_W-1:0] diff;
    logic [IVL_W-1:0]         interval;
  } job_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     num;
    logic [DIV_W-1:0]     den;
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

### sv/vdk_fifo.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
module vdk_fifo
  import vdk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### sv/vdk_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module vdk_div
  import vdk_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     dsh_q;
  logic [QUOT_W-1:0]    quot_q;
  logic                 fits;

  assign fits       = (rem_q >= dsh_q);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder, shifted divisor and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      dsh_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) rem_q <= rem_q - dsh_q;
      quot_q <= {quot_q[QUOT_W-2:0], fits};
      dsh_q  <= dsh_q >> 1;
    end
  end

endmodule

### sv/vdk_front.sv
// front end: takes samples, keeps prior velocities, classifies jobs
`timescale 1ns / 1ps
module vdk_front
  import vdk_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CH_W-1:0]         channel_i,
  input  logic signed [VEL_W-1:0] velocity_i,
  input  logic [IVL_W-1:0]        interval_us_i,
  input  logic                    full_i,
  output logic                    push_o,
  output job_t                    job_o
);

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [VEL_W-1:0] prior_v_q [CHANNELS];
  logic [CHANNELS-1:0]     prior_ok_q;
  logic [IW-1:0]           idx;
  logic                    ch_ok;
  logic                    accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign idx        = IW'(channel_i);
  assign ch_ok      = (32'(channel_i) < CHANNELS);

  // classify the sample and form the velocity difference
  always_comb begin
    job_o.ch       = channel_i;
    job_o.interval = interval_us_i;
    job_o.diff     = {velocity_i[VEL_W-1], velocity_i}
                   - {prior_v_q[idx][VEL_W-1], prior_v_q[idx]};
    if (!ch_ok) job_o.kind = KIND_SKIP;
    else if (prior_ok_q[idx] && (interval_us_i > MIN_IVL)) job_o.kind = KIND_CALC;
    else job_o.kind = KIND_HOLD;
  end

  // prior sample store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_ok_q <= '0;
      for (int i = 0; i < CHANNELS; i++) prior_v_q[i] <= '0;
    end else if (accept && ch_ok) begin
      prior_v_q[idx]  <= velocity_i;
      prior_ok_q[idx] <= 1'b1;
    end
  end

endmodule

### sv/vdk_back.sv
// back end: differentiation, kalman update and result register
`timescale 1ns / 1ps
module vdk_back
  import vdk_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  job_t                    job_i,
  output logic                    pop_o,
  input  logic [31:0]             q_noise_i,
  input  logic [31:0]             r_noise_i,
  input  logic                    filt_en_i,
  output div_req_t                div_req_o,
  input  div_rsp_t                div_rsp_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CH_W-1:0]         out_channel_o,
  output logic signed [ACC_W-1:0] acceleration_o,
  output logic                    updated_o
);

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SAT, S_DIV1, S_RAW, S_DIV2, S_MUL2, S_MUL3, S_UPD, S_OUT
  } state_e;

  state_e                  state_q;
  job_t                    cur_q;
  logic signed [ACC_W-1:0] est_q  [CHANNELS];
  logic [31:0]             cov_q  [CHANNELS];
  logic signed [ACC_W-1:0] held_q [CHANNELS];
  logic [CHANNELS-1:0]     seed_q;
  logic [52:0]             num_q;
  logic                    neg_q;
  logic signed [ACC_W-1:0] raw_q;
  logic [31:0]             pp_q;
  logic [15:0]             gain_q;
  logic signed [49:0]      prod_q;
  logic [31:0]             pnew_q;
  logic signed [ACC_W-1:0] res_q;
  logic                    upd_q;
  logic                    out_valid_q;
  logic [CH_W-1:0]         out_ch_q;
  logic signed [ACC_W-1:0] out_acc_q;
  logic                    out_upd_q;

  logic [IW-1:0]           idx;
  logic [32:0]             dmag;
  logic                    sat;
  logic [32:0]             psum_raw;
  logic [31:0]             pprime;
  logic [33:0]             psum;
  logic signed [32:0]      innov;
  logic signed [49:0]      adj;
  logic signed [ACC_W-1:0] est_new;
  logic [16:0]             one_minus_k;
  logic [48:0]             pmul;
  logic                    out_load;

  assign idx   = IW'(cur_q.ch);
  assign pop_o = (state_q == S_IDLE) && !empty_i;

  // magnitude of the difference and saturation test
  assign dmag = cur_q.diff[DIFF_W-1] ? 33'(-cur_q.diff) : 33'(cur_q.diff);
  assign sat  = ({3'b0, num_q} >= {1'b0, cur_q.interval, 31'b0});

  // predicted covariance and gain denominator
  assign psum_raw = {1'b0, cov_q[idx]} + {1'b0, q_noise_i};
  assign pprime   = psum_raw[32] ? 32'hFFFF_FFFF : psum_raw[31:0];
  assign psum     = {2'b0, pprime} + {2'b0, r_noise_i};

  // innovation, truncated estimate step and covariance scale
  assign innov       = {raw_q[ACC_W-1], raw_q} - {est_q[idx][ACC_W-1], est_q[idx]};
  assign adj         = prod_q[49] ? ((prod_q + 50'sd65535) >>> 16) : (prod_q >>> 16);
  assign est_new     = est_q[idx] + adj[ACC_W-1:0];
  assign one_minus_k = 17'd65536 - {1'b0, gain_q};
  assign pmul        = 49'(one_minus_k) * 49'(pp_q);

  // divider requests
  always_comb begin
    div_req_o = '0;
    if (state_q == S_SAT && !sat) begin
      div_req_o.start = 1'b1;
      div_req_o.num   = {3'b0, num_q};
      div_req_o.den   = {2'b0, cur_q.interval, 30'b0};
      div_req_o.iters = ITER_RAW;
    end else if (state_q == S_RAW && filt_en_i && seed_q[idx]) begin
      div_req_o.start = 1'b1;
      div_req_o.num   = {8'b0, pprime, 16'b0};
      div_req_o.den   = {7'b0, psum, 15'b0};
      div_req_o.iters = ITER_GAIN;
    end
  end

  // output register takes a new result once the old one has gone
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = out_ch_q;
  assign acceleration_o = out_acc_q;
  assign updated_o      = out_upd_q;

  // job sequencer, channel state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      seed_q      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        est_q[i]  <= '0;
        cov_q[i]  <= COV_RESET;
        held_q[i] <= '0;
      end
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cur_q <= job_i;
            upd_q <= 1'b0;
            if (job_i.kind == KIND_CALC) state_q <= S_MUL;
            else begin
              res_q   <= (job_i.kind == KIND_SKIP) ? '0 : held_q[IW'(job_i.ch)];
              state_q <= S_OUT;
            end
          end
        end
        S_MUL: begin
          num_q   <= 53'(dmag) * 53'(MICROS);
          neg_q   <= cur_q.diff[DIFF_W-1];
          state_q <= S_SAT;
        end
        S_SAT: begin
          if (sat) begin
            raw_q   <= neg_q ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            state_q <= S_RAW;
          end else state_q <= S_DIV1;
        end
        S_DIV1: begin
          if (div_rsp_i.done) begin
            raw_q   <= neg_q ? -div_rsp_i.quot : div_rsp_i.quot;
            state_q <= S_RAW;
          end
        end
        S_RAW: begin
          upd_q <= 1'b1;
          if (!filt_en_i) begin
            held_q[idx] <= raw_q;
            res_q       <= raw_q;
            state_q     <= S_OUT;
          end else if (!seed_q[idx]) begin
            est_q[idx]  <= raw_q;
            seed_q[idx] <= 1'b1;
            held_q[idx] <= raw_q;
            res_q       <= raw_q;
            state_q     <= S_OUT;
          end else begin
            pp_q    <= pprime;
            state_q <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp_i.done) begin
            gain_q  <= div_rsp_i.quot[15:0];
            state_q <= S_MUL2;
          end
        end
        S_MUL2: begin
          prod_q  <= 50'(innov) * 50'($signed({1'b0, gain_q}));
          state_q <= S_MUL3;
        end
        S_MUL3: begin
          pnew_q  <= pmul[47:16];
          state_q <= S_UPD;
        end
        S_UPD: begin
          est_q[idx]  <= est_new;
          cov_q[idx]  <= pnew_q;
          held_q[idx] <= est_new;
          res_q       <= est_new;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_ch_q  <= cur_q.ch;
            out_acc_q <= res_q;
            out_upd_q <= upd_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/velocity_differentiator_kalman_bank.sv
// out-of-range, first-sample and interval-of-one-or-less samples go straight to the result;
// others take the raw acceleration from the divider, and when filtered the divider
// runs a second pass for the gain once the channel is seeded; saturated values skip the first pass
// the back end works one sample at a time and the front queues up to two more; a stalled
// result holds the back end until it leaves
// asynchronous active-low reset clears all channel state and restores register defaults
`timescale 1ns / 1ps
module velocity_differentiator_kalman_bank
  import vdk_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CH_W-1:0]         channel_i,
  input  logic signed [VEL_W-1:0] velocity_i,
  input  logic [IVL_W-1:0]        interval_us_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CH_W-1:0]         out_channel_o,
  output logic signed [ACC_W-1:0] acceleration_o,
  output logic                    updated_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  logic [31:0] q_noise_q;
  logic [31:0] r_noise_q;
  logic        filt_en_q;
  logic [31:0] clamped;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  job_t        job_in;
  job_t        job_out;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign cfg_ready_o = 1'b1;
  assign clamped     = (cfg_data_i == '0) ? 32'd1 : cfg_data_i;

  // configuration registers; noise kept at one lsb or more; writes to the initial covariance
  // are ignored, and reset restores the fixed default covariance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= QN_RESET;
      r_noise_q <= RN_RESET;
      filt_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PROCESS_NOISE: q_noise_q <= clamped;
        REG_MEAS_NOISE:    r_noise_q <= clamped;
        REG_INIT_COV:      ;
        REG_FILTER_EN:     filt_en_q <= cfg_data_i[0];
        default:           ;
      endcase
    end
  end

  vdk_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .channel_i    (channel_i),
    .velocity_i   (velocity_i),
    .interval_us_i(interval_us_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  vdk_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(job_in),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (job_out),
    .empty_o    (empty)
  );

  vdk_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  vdk_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .job_i         (job_out),
    .pop_o         (pop),
    .q_noise_i     (q_noise_q),
    .r_noise_i     (r_noise_q),
    .filt_en_i     (filt_en_q),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .acceleration_o(acceleration_o),
    .updated_o     (updated_o)
  );

endmodule

### sv/vdk_checker.sv
// port-level checks of the kalman bank, bound to the top level
`timescale 1ns / 1ps
module vdk_checker
  import vdk_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [CH_W-1:0]         out_channel_o,
  input logic signed [ACC_W-1:0] acceleration_o,
  input logic                    updated_o
);

  logic [2:0] pending_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // samples taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(acceleration_o)
      && $stable(out_channel_o) && $stable(updated_o))
    else $error("stalled result changed");

  // no result without an outstanding sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result without sample");

  // an empty block takes samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd0 |-> !in_stall_o)
    else $error("stall while empty");

  // out-of-range channels give a plain zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(out_channel_o) >= CHANNELS) |-> acceleration_o == '0 && !updated_o)
    else $error("out-of-range channel produced data");

endmodule

bind velocity_differentiator_kalman_bank vdk_checker #(.CHANNELS(CHANNELS)) u_vdk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_channel_o (out_channel_o),
  .acceleration_o(acceleration_o),
  .updated_o     (updated_o)
);

### tb/tb.sv
// testbench for the velocity differentiator kalman bank
`timescale 1ns / 1ps
module tb;
  import vdk_pkg::*;

  typedef struct {
    logic [CH_W-1:0] ch;
    logic [31:0]     acc;
    logic            upd;
  } accel_t;

  typedef struct {
    logic [CH_W-1:0]  ch;
    int               vel;
    logic [IVL_W-1:0] ivl;
    bit               typed;
    logic [31:0]      acc;
    logic             upd;
  } dir_row_t;

  typedef struct {
    logic [31:0] qn;
    logic [31:0] rn;
    logic [31:0] pinit;
    logic        en;
  } cfg_set_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [CH_W-1:0]         channel_i = '0;
  logic signed [VEL_W-1:0] velocity_i = '0;
  logic [IVL_W-1:0]        interval_us_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [CH_W-1:0]         out_channel_o;
  logic signed [ACC_W-1:0] acceleration_o;
  logic                    updated_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [31:0]             cfg_data_i = '0;

  velocity_differentiator_kalman_bank dut (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted channel state and register copies
  int          last_vel [CHANNELS_DEF];
  bit          last_ok  [CHANNELS_DEF];
  int          estimate [CHANNELS_DEF];
  logic [31:0] covar    [CHANNELS_DEF];
  bit          seeded   [CHANNELS_DEF];
  int          held     [CHANNELS_DEF];
  logic [31:0] q_reg = QN_RESET;
  logic [31:0] r_reg = RN_RESET;
  logic [31:0] p_reg = COV_RESET;
  logic        en_reg = 1'b1;

  accel_t accel_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  int     items_sent = 0;

  initial begin
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      last_vel[i] = 0;
      last_ok[i] = 0;
      estimate[i] = 0;
      covar[i] = COV_RESET;
      seeded[i] = 0;
      held[i] = 0;
    end
  end

  // acceleration predictor, advances the channel state by one sample
  function automatic accel_t predict_accel(logic [CH_W-1:0] ch, int vel,
                                           logic [IVL_W-1:0] ivl);
    accel_t r;
    longint d, raw, q, rn, p, g, inn;
    r.ch = ch;
    r.upd = 1'b0;
    if (last_ok[ch] && ivl > MIN_IVL) begin
      d = longint'(vel) - longint'(last_vel[ch]);
      raw = (d * 64'sd1000000) / longint'(ivl);
      if (raw > 64'sd2147483647) raw = 64'sd2147483647;
      if (raw < -64'sd2147483648) raw = -64'sd2147483648;
      if (!en_reg) begin
        held[ch] = int'(raw);
      end else if (!seeded[ch]) begin
        estimate[ch] = int'(raw);
        seeded[ch] = 1;
        held[ch] = int'(raw);
      end else begin
        q = (q_reg == 0) ? 1 : longint'(q_reg);
        rn = (r_reg == 0) ? 1 : longint'(r_reg);
        p = longint'(covar[ch]) + q;
        if (p > 64'sd4294967295) p = 64'sd4294967295;
        g = (p <<< 16) / (p + rn);
        inn = raw - longint'(estimate[ch]);
        estimate[ch] = int'(longint'(estimate[ch]) + (inn * g) / 64'sd65536);
        covar[ch] = 32'(((64'sd65536 - g) * p) >>> 16);
        held[ch] = estimate[ch];
      end
      r.upd = 1'b1;
    end
    last_vel[ch] = vel;
    last_ok[ch] = 1;
    r.acc = held[ch];
    return r;
  endfunction

  // send one sample, gaps sometimes come between bursts
  task automatic send_sample(logic [CH_W-1:0] ch, int vel, logic [IVL_W-1:0] ivl,
                             bit typed = 0, logic [31:0] acc = '0, logic upd = 1'b0);
    accel_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i = 1'b1;
    channel_i = ch;
    velocity_i = vel;
    interval_us_i = ivl;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_accel(ch, vel, ivl);
    // rows with a value read off by hand check that value instead
    if (typed) begin
      r.acc = acc;
      r.upd = upd;
    end
    accel_q.insert(accel_q.size(), r);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (accel_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PROCESS_NOISE: q_reg = data;
      REG_MEAS_NOISE:    r_reg = data;
      REG_INIT_COV:      p_reg = data;   // recorded only, not used by the predictor
      REG_FILTER_EN:     en_reg = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_cfg(cfg_set_t c);
    wait_drained();
    write_reg(REG_PROCESS_NOISE, c.qn);
    write_reg(REG_MEAS_NOISE, c.rn);
    write_reg(REG_INIT_COV, c.pinit);
    write_reg(REG_FILTER_EN, {31'd0, c.en});
  endtask

  // random sample: mostly smooth motion on a few channels, some noise
  task automatic send_random();
    logic [CH_W-1:0]  ch;
    int               vel;
    logic [IVL_W-1:0] ivl;
    ch = ($urandom_range(0, 3) == 0) ? CH_W'($urandom) : CH_W'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       vel = $urandom;
      1:       vel = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      default: vel = last_vel[ch] + $signed($urandom_range(0, 400000)) - 200000;
    endcase
    case ($urandom_range(0, 9))
      0:       ivl = $urandom_range(0, 1);
      1:       ivl = IVL_W'($urandom);
      2:       ivl = $urandom_range(2, 20);
      default: ivl = $urandom_range(500, 2000);
    endcase
    send_sample(ch, vel, ivl);
  endtask

  // receiver stall pattern, in randomly chosen modes
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(100, 300)) begin
        @(negedge clk_i);
        case (mode)
          0:       out_stall_i = 1'b0;
          1:       out_stall_i = ($urandom_range(0, 3) == 0);
          2:       out_stall_i = ($urandom_range(0, 3) != 0);
          default: out_stall_i = ~out_stall_i;
        endcase
      end
    end
  end

  // result check against oldest expected transfer
  always @(posedge clk_i) begin
    accel_t w;
    if (out_valid_o && !out_stall_i) begin
      if (accel_q.size() == 0) begin
        $display("%t: unexpected result ch=%0d acc=%h upd=%b", $time,
                 out_channel_o, acceleration_o, updated_o);
        errors++;
      end else begin
        w = accel_q.pop_front();
        if (out_channel_o !== w.ch) begin
          $display("%t: channel expected %0d actual %0d", $time, w.ch, out_channel_o);
          errors++;
        end
        if (acceleration_o !== w.acc) begin
          $display("%t: acceleration ch %0d expected %h actual %h", $time, w.ch,
                   w.acc, acceleration_o);
          errors++;
        end
        if (updated_o !== w.upd) begin
          $display("%t: updated ch %0d expected %b actual %b", $time, w.ch,
                   w.upd, updated_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** velocity_differentiator_kalman_bank: FAILED **");
      $finish;
    end
  end

  dir_row_t dir_tab[] = '{
    '{4'd0,  0,           24'd0,       1, 32'h0,        1'b0},  // first sample
    '{4'd0,  100,         24'd1,       1, 32'h0,        1'b0},  // interval of one
    '{4'd0,  32'h7fffffff, 24'd2,      1, 32'h7fffffff, 1'b1},  // saturates high, seeds
    '{4'd0,  32'h80000000, 24'd2,      0, 32'h0,        1'b0},  // saturates low
    '{4'd1,  32'h80000000, 24'hffffff, 1, 32'h0,        1'b0},
    '{4'd1,  32'h7fffffff, 24'hffffff, 0, 32'h0,        1'b0},
    '{4'd2,  5,           24'd0,       1, 32'h0,        1'b0},
    '{4'd2,  5,           24'd3,       1, 32'h0,        1'b1},  // no change seeds zero
    '{4'd2,  65536,       24'd1000,    0, 32'h0,        1'b0},
    '{4'd2,  -65536,      24'd1000,    0, 32'h0,        1'b0},
    '{4'd2,  -65536,      24'd0,       0, 32'h0,        1'b0},
    '{4'd15, 123456,      24'd500,     1, 32'h0,        1'b0},
    '{4'd15, 223456,      24'd2,       0, 32'h0,        1'b0},
    '{4'd15, -1,          24'h800000,  0, 32'h0,        1'b0},
    '{4'd3,  0,           24'd1,       1, 32'h0,        1'b0},
    '{4'd3,  7,           24'd1,       1, 32'h0,        1'b0},
    '{4'd3,  -7,          24'd2,       0, 32'h0,        1'b0}
  };

  cfg_set_t cfg_tab[] = '{
    '{32'd0,        32'd0,        32'd0,        1'b1},
    '{32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0},
    '{32'hffffffff, 32'd1,        32'd65536,    1'b1},
    '{32'd1,        32'hffffffff, 32'd12345,    1'b1},
    '{32'd65536,    32'd65536,    32'd0,        1'b0},
    '{QN_RESET,     RN_RESET,     COV_RESET,    1'b1}
  };

  // stimulus
  initial begin
    cfg_set_t c;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[i])
      send_sample(dir_tab[i].ch, dir_tab[i].vel, dir_tab[i].ivl, dir_tab[i].typed,
                  dir_tab[i].acc, dir_tab[i].upd);
    for (int ph = 0; ph < cfg_tab.size() + 1; ph++) begin
      if (ph < cfg_tab.size()) begin
        c = cfg_tab[ph];
      end else begin
        c.qn = $urandom;
        c.rn = $urandom;
        c.pinit = $urandom;
        c.en = 1'b1;
      end
      apply_cfg(c);
      for (int k = 0; k < 85; k++) begin
        // hold off once until everything is back
        if (ph == 2 && k == 40) while (accel_q.size() > 0) @(negedge clk_i);
        send_random();
      end
    end
    wait_drained();
    if (errors == 0) $display("** velocity_differentiator_kalman_bank: PASSED **");
    else $display("** velocity_differentiator_kalman_bank: FAILED **");
    $finish;
  end

endmodule
